>>> rtl/flagged_frame_checker_defines.svh
// assertion helpers shared by the frame checker modules
// each expects clk and rst in scope
`ifndef FLAGGED_FRAME_CHECKER_DEFINES_SVH
`define FLAGGED_FRAME_CHECKER_DEFINES_SVH

// same-cycle implication
`define FFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffc check failed");

// next-cycle implication
`define FFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffc check failed");

`endif

>>> rtl/ffc_pkg.sv
package ffc_pkg;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // register indexes
  localparam logic [1:0] REG_START_FLAG  = 2'd0;
  localparam logic [1:0] REG_END_FLAG    = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

  localparam logic [7:0] START_FLAG_RST  = 8'd126;
  localparam logic [7:0] END_FLAG_RST    = 8'd126;
  localparam logic [7:0] MAX_PAYLOAD_RST = 8'd64;

  // parser phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_ADDR    = 3'd1;
  localparam logic [2:0] PH_CMD     = 3'd2;
  localparam logic [2:0] PH_LEN     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_CHECK   = 3'd5;
  localparam logic [2:0] PH_END     = 3'd6;

  // verdict codes
  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_LONG  = 3'd1;
  localparam logic [2:0] ERR_START = 3'd2;
  localparam logic [2:0] ERR_END   = 3'd3;
  localparam logic [2:0] ERR_CHECK = 3'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic [7:0] start_flag_value;
    logic [7:0] end_flag_value;
    logic [7:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [3:0] source_id;
    logic [3:0] receiver_id;
    logic [3:0] command_id;
    logic [3:0] command_flags;
    logic [7:0] frame_length;
    logic [2:0] error_code;
    logic       last_of_frame;
  } result_t;

endpackage

>>> rtl/ffc_parser.sv
`include "flagged_frame_checker_defines.svh"

module ffc_parser (
  input  logic             clk,
  input  logic             rst,
  input  ffc_pkg::cfg_t    cfg,
  input  logic             fire,
  input  logic [7:0]       in_byte,
  input  logic             in_first,
  output logic             res_valid,
  output ffc_pkg::result_t res
);
  import ffc_pkg::*;

  logic [2:0] phase, phase_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] received_check, received_check_next;
  logic       start_ok, start_ok_next;
  logic [7:0] address_byte, address_byte_next;
  logic [7:0] command_byte, command_byte_next;
  logic [7:0] length_byte, length_byte_next;

  logic [7:0] xor_acc;
  logic [7:0] calc;

  assign xor_acc = running_xor ^ in_byte;
  assign calc    = xor_acc | 8'h01;

  always_comb begin
    phase_next          = phase;
    bytes_left_next     = bytes_left;
    running_xor_next    = running_xor;
    received_check_next = received_check;
    start_ok_next       = start_ok;
    address_byte_next   = address_byte;
    command_byte_next   = command_byte;
    length_byte_next    = length_byte;
    res_valid           = 1'b0;
    res                 = '0;
    if (fire) begin
      if (in_first) begin
        start_ok_next       = (in_byte == cfg.start_flag_value);
        running_xor_next    = in_byte;
        bytes_left_next     = '0;
        received_check_next = '0;
        address_byte_next   = '0;
        command_byte_next   = '0;
        length_byte_next    = '0;
        phase_next          = PH_ADDR;
      end else begin
        // verdict header fields come from the stored bytes; a length verdict takes its length from the current byte
        res.source_id     = address_byte[7:4];
        res.receiver_id   = address_byte[3:0];
        res.command_id    = command_byte[7:4];
        res.command_flags = command_byte[3:0];
        res.frame_length  = length_byte;
        unique case (phase)
          PH_ADDR: begin
            address_byte_next = in_byte;
            running_xor_next  = xor_acc;
            phase_next        = PH_CMD;
          end
          PH_CMD: begin
            command_byte_next = in_byte;
            running_xor_next  = xor_acc;
            phase_next        = PH_LEN;
          end
          PH_LEN: begin
            length_byte_next = in_byte;
            running_xor_next = xor_acc;
            if (in_byte > cfg.max_payload) begin
              res_valid         = 1'b1;
              res.result_kind   = KIND_VERDICT;
              res.frame_length  = in_byte;
              res.error_code    = ERR_LONG;
              res.last_of_frame = 1'b1;
              phase_next        = PH_IDLE;
            end else begin
              bytes_left_next = in_byte;
              phase_next      = (in_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            running_xor_next = xor_acc;
            bytes_left_next  = bytes_left - 8'd1;
            if (bytes_left == 8'd1) begin
              phase_next = PH_CHECK;
            end
            res_valid        = 1'b1;
            res              = '0;
            res.result_kind  = KIND_PAYLOAD;
            res.payload_byte = in_byte;
          end
          PH_CHECK: begin
            received_check_next = in_byte;
            phase_next          = PH_END;
          end
          PH_END: begin
            running_xor_next  = xor_acc;
            res_valid         = 1'b1;
            res.result_kind   = KIND_VERDICT;
            res.last_of_frame = 1'b1;
            if (!start_ok) begin
              res.error_code = ERR_START;
            end else if (in_byte != cfg.end_flag_value) begin
              res.error_code = ERR_END;
            end else if (calc != received_check) begin
              res.error_code = ERR_CHECK;
            end else begin
              res.error_code = ERR_OK;
            end
            phase_next = PH_IDLE;
          end
          default: begin
            // unmarked bytes outside a frame are dropped
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bytes_left     <= '0;
      running_xor    <= '0;
      received_check <= '0;
      start_ok       <= 1'b0;
      address_byte   <= '0;
      command_byte   <= '0;
      length_byte    <= '0;
    end else begin
      phase          <= phase_next;
      bytes_left     <= bytes_left_next;
      running_xor    <= running_xor_next;
      received_check <= received_check_next;
      start_ok       <= start_ok_next;
      address_byte   <= address_byte_next;
      command_byte   <= command_byte_next;
      length_byte    <= length_byte_next;
    end
  end

  `FFC_ASSERT_NEXT(a_verdict_ends_frame, fire && res_valid && res.result_kind == KIND_VERDICT, phase == PH_IDLE)
  `FFC_ASSERT_NEXT(a_marked_opens_frame, fire && in_first, phase == PH_ADDR && running_xor == $past(in_byte))
  `FFC_ASSERT_NOW(a_payload_count_live, phase == PH_PAYLOAD, bytes_left != 8'd0)

endmodule

>>> rtl/flagged_frame_checker.sv
// a byte enters the input register and is parsed once the result buffer has a free slot; its
// result, if any, is written into the result buffer, which drives the output
// throughput: one byte per cycle while the result buffer is not full, through the parser
// between the input register and the two-entry result buffer
// reset: synchronous, parser returns to idle, result buffer empties, registers reload defaults
`include "flagged_frame_checker_defines.svh"

module flagged_frame_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 data_byte,
  input  logic                       first_of_message,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       result_kind,
  output logic [7:0]                 payload_byte,
  output logic [3:0]                 source_id,
  output logic [3:0]                 receiver_id,
  output logic [3:0]                 command_id,
  output logic [3:0]                 command_flags,
  output logic [7:0]                 frame_length,
  output logic [2:0]                 error_code,
  output logic                       last_of_frame,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ffc_pkg::ADDR_W-1:0] paddr,
  input  logic [ffc_pkg::DATA_W-1:0] pwdata,
  output logic [ffc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import ffc_pkg::*;

  cfg_t       cfg;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_first;
  logic       s1_fire;
  logic       in_txn;

  logic       res_valid;
  result_t    res;

  result_t    buf_q [2];
  logic       rd_ptr;
  logic [1:0] cnt, cnt_next;
  logic       push, pop;
  logic       wr_ptr;
  result_t    head;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_flag_value <= START_FLAG_RST;
      cfg.end_flag_value   <= END_FLAG_RST;
      cfg.max_payload      <= MAX_PAYLOAD_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_START_FLAG:  cfg.start_flag_value <= pwdata[7:0];
        REG_END_FLAG:    cfg.end_flag_value   <= pwdata[7:0];
        REG_MAX_PAYLOAD: cfg.max_payload      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_START_FLAG:  prdata[7:0] = cfg.start_flag_value;
      REG_END_FLAG:    prdata[7:0] = cfg.end_flag_value;
      REG_MAX_PAYLOAD: prdata[7:0] = cfg.max_payload;
      default:         prdata = '0;
    endcase
  end

  // input register; parses whenever the result buffer has a free slot
  assign s1_fire  = s1_valid && (cnt != 2'd2);
  assign in_ready = !s1_valid || s1_fire;
  assign in_txn   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_txn) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_txn) begin
      s1_byte  <= data_byte;
      s1_first <= first_of_message;
    end
  end

  ffc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .fire      (s1_fire),
    .in_byte   (s1_byte),
    .in_first  (s1_first),
    .res_valid (res_valid),
    .res       (res)
  );

  // two-entry result buffer
  assign push     = s1_fire && res_valid;
  assign pop      = out_valid && out_ready;
  assign wr_ptr   = rd_ptr ^ cnt[0];
  assign cnt_next = cnt + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      rd_ptr <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= res;
    end
  end

  assign out_valid     = (cnt != 2'd0);
  assign head          = buf_q[rd_ptr];
  assign result_kind   = head.result_kind;
  assign payload_byte  = head.payload_byte;
  assign source_id     = head.source_id;
  assign receiver_id   = head.receiver_id;
  assign command_id    = head.command_id;
  assign command_flags = head.command_flags;
  assign frame_length  = head.frame_length;
  assign error_code    = head.error_code;
  assign last_of_frame = head.last_of_frame;

  `FFC_ASSERT_NOW(a_cnt_bound, 1'b1, cnt != 2'd3)
  `FFC_ASSERT_NOW(a_kind_matches_last, out_valid, result_kind == last_of_frame)
  `FFC_ASSERT_NEXT(a_full_holds_stage, s1_valid && cnt == 2'd2 && !pop, s1_valid && $stable(s1_byte) && $stable(s1_first))

endmodule

>>> sim/flagged_frame_checker_test.sv
module flagged_frame_checker_test;
  import ffc_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [7:0] b;
    logic       mark;
    bit         pinned;
    result_t    res;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          data_byte;
  logic                first_of_message;
  logic                out_valid;
  logic                out_ready;
  logic                result_kind;
  logic [7:0]          payload_byte;
  logic [3:0]          source_id;
  logic [3:0]          receiver_id;
  logic [3:0]          command_id;
  logic [3:0]          command_flags;
  logic [7:0]          frame_length;
  logic [2:0]          error_code;
  logic                last_of_frame;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // parser copy kept alongside the block
  cfg_t       cfg_now;
  logic [2:0] parse_phase = PH_IDLE;
  logic [7:0] payload_left = '0;
  logic [7:0] xor_acc = '0;
  logic [7:0] check_rx = '0;
  logic       start_ok = 1'b0;
  logic [7:0] hdr_addr = '0;
  logic [7:0] hdr_cmd = '0;
  logic [7:0] hdr_len = '0;

  result_t    frame_results[$];
  stim_row_t  directed_rows[$];
  bit         full_rate = 1'b0;
  int         error_count = 0;
  int         parsed_items = 0;
  int         payload_out = 0;
  int         settings_count = 1;
  int         verdict_tally[0:4] = '{default: 0};

  flagged_frame_checker dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic result_t verdict_of(input logic [7:0] addr, input logic [7:0] cmd,
                                         input logic [7:0] len, input logic [2:0] code);
    result_t r;
    r = '0;
    r.result_kind   = KIND_VERDICT;
    r.source_id     = addr[7:4];
    r.receiver_id   = addr[3:0];
    r.command_id    = cmd[7:4];
    r.command_flags = cmd[3:0];
    r.frame_length  = len;
    r.error_code    = code;
    r.last_of_frame = 1'b1;
    return r;
  endfunction

  function automatic result_t payload_of(input logic [7:0] b);
    result_t r;
    r = '0;
    r.result_kind  = KIND_PAYLOAD;
    r.payload_byte = b;
    return r;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic mark,
                            output bit produced, output result_t res);
    logic [2:0] code;
    produced = 1'b0;
    res = '0;
    if (mark) begin
      start_ok = (b == cfg_now.start_flag_value);
      xor_acc = b;
      payload_left = '0;
      check_rx = '0;
      hdr_addr = '0;
      hdr_cmd = '0;
      hdr_len = '0;
      parse_phase = PH_ADDR;
      parsed_items++;
      return;
    end
    if (parse_phase != PH_IDLE) parsed_items++;
    case (parse_phase)
      PH_ADDR: begin
        hdr_addr = b;
        xor_acc ^= b;
        parse_phase = PH_CMD;
      end
      PH_CMD: begin
        hdr_cmd = b;
        xor_acc ^= b;
        parse_phase = PH_LEN;
      end
      PH_LEN: begin
        hdr_len = b;
        xor_acc ^= b;
        if (b > cfg_now.max_payload) begin
          res = verdict_of(hdr_addr, hdr_cmd, hdr_len, ERR_LONG);
          produced = 1'b1;
          parse_phase = PH_IDLE;
        end else begin
          payload_left = b;
          parse_phase = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        xor_acc ^= b;
        payload_left--;
        if (payload_left == 8'd0) parse_phase = PH_CHECK;
        res = payload_of(b);
        produced = 1'b1;
      end
      PH_CHECK: begin
        check_rx = b;
        parse_phase = PH_END;
      end
      PH_END: begin
        xor_acc ^= b;
        if (!start_ok) code = ERR_START;
        else if (b != cfg_now.end_flag_value) code = ERR_END;
        else if ((xor_acc | 8'h01) != check_rx) code = ERR_CHECK;
        else code = ERR_OK;
        res = verdict_of(hdr_addr, hdr_cmd, hdr_len, code);
        produced = 1'b1;
        parse_phase = PH_IDLE;
      end
      default: parse_phase = PH_IDLE;
    endcase
  endtask

  // mostly back to back, some short gaps, a few long ones
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(99);
    if (full_rate || pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic mark,
                           input bit pinned = 1'b0, input result_t pinned_res = '0);
    int      gap;
    bit      produced;
    result_t res;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    data_byte = b;
    first_of_message = mark;
    do @(posedge clk); while (!in_ready);
    parse_byte(b, mark, produced, res);
    if (produced) frame_results.push_back(pinned ? pinned_res : res);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (frame_results.size() != 0) @(posedge clk);
    // ignored bytes may still be in the pipe
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [7:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = {24'($urandom), value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_START_FLAG:  cfg_now.start_flag_value = value;
      REG_END_FLAG:    cfg_now.end_flag_value = value;
      REG_MAX_PAYLOAD: cfg_now.max_payload = value;
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apply_setting(input logic [7:0] sflag, input logic [7:0] eflag,
                               input logic [7:0] maxlen);
    drain();
    reg_write(REG_START_FLAG, sflag);
    reg_write(REG_END_FLAG, eflag);
    reg_write(REG_MAX_PAYLOAD, maxlen);
    settings_count++;
  endtask

  function automatic void add_row(input logic [7:0] b, input logic mark,
                                  input bit pinned = 1'b0, input result_t res = '0);
    stim_row_t r;
    r.b = b;
    r.mark = mark;
    r.pinned = pinned;
    r.res = res;
    directed_rows.push_back(r);
  endfunction

  // mostly well-formed frames with random content; some flags, checksums and
  // lengths spoilt, some frames cut short by the next marked byte
  task automatic send_random_frame();
    logic [7:0] frame_bytes[$];
    logic [7:0] len;
    logic [7:0] eflag;
    logic [7:0] ck;
    int         pick;
    int         cut;
    full_rate = ($urandom_range(4) == 0);
    pick = $urandom_range(99);
    if (pick < 70) len = 8'($urandom_range(0, 4));
    else if (pick < 88) len = 8'($urandom_range(0, cfg_now.max_payload));
    else if (pick < 96) len = cfg_now.max_payload + 8'($urandom_range(0, 1));
    else len = 8'($urandom);
    frame_bytes.push_back(($urandom_range(9) == 0) ? 8'($urandom) : cfg_now.start_flag_value);
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(len);
    repeat (len) frame_bytes.push_back(8'($urandom));
    eflag = ($urandom_range(9) == 0) ? 8'($urandom) : cfg_now.end_flag_value;
    ck = eflag;
    foreach (frame_bytes[i]) ck ^= frame_bytes[i];
    ck |= 8'h01;
    if ($urandom_range(9) == 0) ck ^= 8'($urandom_range(1, 255));
    frame_bytes.push_back(ck);
    frame_bytes.push_back(eflag);
    if ($urandom_range(19) == 0) begin
      cut = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
    foreach (frame_bytes[i]) send_item(frame_bytes[i], i == 0);
    if ($urandom_range(9) == 0) repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b0);
  endtask

  task automatic run_random(input int n);
    int target;
    target = parsed_items + n;
    while (parsed_items < target) send_random_frame();
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  initial begin
    out_ready = 1'b0;
    forever begin : ready_pattern
      int run;
      run = $urandom_range(1, 40);
      @(negedge clk);
      out_ready = 1'b1;
      repeat (run - 1) @(negedge clk);
      run = idle_len();
      if (run > 0) begin
        @(negedge clk);
        out_ready = 1'b0;
        repeat (run - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{result_kind, payload_byte, source_id, receiver_id, command_id,
              command_flags, frame_length, error_code, last_of_frame};
      if (got.result_kind == KIND_PAYLOAD) payload_out++;
      else if (got.error_code <= ERR_CHECK) verdict_tally[got.error_code]++;
      if (frame_results.size() == 0) begin
        $error("result transaction with nothing pending: kind %0d", got.result_kind);
        error_count++;
      end else begin
        want = frame_results.pop_front();
        check_field("result_kind", 8'(want.result_kind), 8'(got.result_kind));
        check_field("payload_byte", want.payload_byte, got.payload_byte);
        check_field("source_id", 8'(want.source_id), 8'(got.source_id));
        check_field("receiver_id", 8'(want.receiver_id), 8'(got.receiver_id));
        check_field("command_id", 8'(want.command_id), 8'(got.command_id));
        check_field("command_flags", 8'(want.command_flags), 8'(got.command_flags));
        check_field("frame_length", want.frame_length, got.frame_length);
        check_field("error_code", 8'(want.error_code), 8'(got.error_code));
        check_field("last_of_frame", 8'(want.last_of_frame), 8'(got.last_of_frame));
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    first_of_message = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_now = '{START_FLAG_RST, END_FLAG_RST, MAX_PAYLOAD_RST};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // well-formed frame, extreme header nibbles and payload bytes
    add_row(8'h7E, 1'b1);
    add_row(8'hF0, 1'b0);
    add_row(8'h0F, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'h00, 1'b0, 1'b1, payload_of(8'h00));
    add_row(8'hFF, 1'b0, 1'b1, payload_of(8'hFF));
    add_row(8'h03, 1'b0);
    add_row(8'h7E, 1'b0);
    // length over the limit, then a stray byte while idle
    add_row(8'h7E, 1'b1);
    add_row(8'hAB, 1'b0);
    add_row(8'hCD, 1'b0);
    add_row(8'hFF, 1'b0, 1'b1, verdict_of(8'hAB, 8'hCD, 8'hFF, ERR_LONG));
    add_row(8'h55, 1'b0);
    // wrong start flag outranks wrong end flag and checksum
    add_row(8'h00, 1'b1);
    add_row(8'h5A, 1'b0);
    add_row(8'hA5, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b1, verdict_of(8'h5A, 8'hA5, 8'h00, ERR_START));
    // restart right after a start flag, zero length, wrong end flag
    add_row(8'h7E, 1'b1);
    add_row(8'h7E, 1'b1);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h7F, 1'b0);
    add_row(8'h00, 1'b0, 1'b1, verdict_of(8'h00, 8'h00, 8'h00, ERR_END));
    // checksum off by bit 0
    add_row(8'h7E, 1'b1);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h7E, 1'b0, 1'b1, verdict_of(8'h00, 8'h00, 8'h00, ERR_CHECK));
    foreach (directed_rows[i])
      send_item(directed_rows[i].b, directed_rows[i].mark,
                directed_rows[i].pinned, directed_rows[i].res);

    run_random(400);
    apply_setting(8'h00, 8'hFF, 8'd0);
    // no register behind this address, nothing may change
    reg_write(REG_UNUSED, 8'($urandom));
    run_random(330);
    apply_setting(8'hFF, 8'h00, 8'd255);
    run_random(330);
    for (int k = 0; k < 3; k++) begin
      apply_setting(8'($urandom), 8'($urandom),
                    (k == 0) ? 8'($urandom) : 8'($urandom_range(1, 12)));
      run_random(330);
    end
    drain();

    $display("covered %0d parsed bytes under %0d register settings, %0d payload bytes out",
             parsed_items, settings_count, payload_out);
    $display("verdicts ok/long/start/end/checksum: %0d/%0d/%0d/%0d/%0d",
             verdict_tally[0], verdict_tally[1], verdict_tally[2],
             verdict_tally[3], verdict_tally[4]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/ffc_pkg.sv
rtl/ffc_parser.sv
rtl/flagged_frame_checker.sv
sim/flagged_frame_checker_test.sv
